FILE: sv/ccr_pkg.sv
// Shared types and constants for the closed Catmull-Rom spline evaluator.
// Holds field widths, fixed-point layout, opcode and sequencer state codes.
// No dependencies; every other file of the block imports this package.
package ccr_pkg;

  // Field widths of the input and result beats.
  localparam int PIDX_W    = 6;
  localparam int COORD_W   = 16;
  localparam int PARAM_T_W = 22;
  localparam int POS_W     = 18;
  localparam int GRAD_W    = 20;
  localparam int AP_W      = 7;

  // Fixed-point layout of the curve parameter.
  localparam int T_FRAC_BITS = 16;
  localparam int SEG_W       = PARAM_T_W - T_FRAC_BITS;

  // Reset value of the active point count.
  localparam logic [AP_W-1:0] AP_RESET = AP_W'(10);

  // Basis coefficients, including the doubled and tripled forms, fit 21 bits.
  localparam int COEF_W = 21;

  // The Horner accumulator only has to be exact in the bits that reach the outputs.
  localparam int POS_LSB  = 3 * T_FRAC_BITS + 1;
  localparam int GRAD_LSB = 2 * T_FRAC_BITS + 1;
  localparam int ACC_W    = POS_LSB + POS_W;

  // Digit-serial multiply by the fraction.
  localparam int DIG_W     = 4;
  localparam int N_DIG     = T_FRAC_BITS / DIG_W;
  localparam int DIG_CNT_W = $clog2(N_DIG);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INDEX,
    ST_READ,
    ST_LAUNCH,
    ST_WAIT
  } state_e;

  // One Horner chain: lead coefficient, the addend for each step, last step number.
  typedef struct packed {
    logic signed [COEF_W-1:0] lead;
    logic signed [COEF_W-1:0] add0;
    logic signed [COEF_W-1:0] add1;
    logic signed [COEF_W-1:0] add2;
    logic [1:0]               last_step;
  } mac_cfg_t;

endpackage

FILE: sv/closed_catmull_rom_spline_eval_core.sv
// Closed uniform Catmull-Rom spline evaluator: top level with the sequencer.
// Depends on ccr_pkg, ccr_point_mem, ccr_seg_index and ccr_horner_mac.
//
// Usage. One command beat is taken at a rising edge where start is high and
// busy is low. A write beat (opcode 0) stores point_x/point_z into slot
// point_index at the accepting edge; busy stays low and no result follows. Slots
// at or above MAX_POINTS are ignored. An evaluate beat (opcode 1) raises busy
// and yields exactly one result beat: pos_x/pos_z and grad_x/grad_z shown for
// one cycle with result_valid_o high. The receiver cannot stall, so the beat
// is gone after that cycle; busy is already low in it, so the next command
// may be taken at the same edge.
// An evaluate beat runs in order: the bit-serial segment modulo, one step per
// segment bit; four reads through the single read port of the point memory;
// and four Horner chains (position x, slope x, position z, slope z) on one
// multiply-accumulate unit that takes one 4-bit digit of the fraction per cycle,
// with a launch and a hand-back step per chain. A new command is taken only
// when busy is low, at the earliest together with the result beat.
// active_points is written through active_points_we_i. The user must write it
// only while the block is idle; the block itself does not enforce this.
// Reset sets the point count to 10 and returns to idle; the point memory is
// not cleared, so every slot used by an evaluation must be written first.
module closed_catmull_rom_spline_eval_core import ccr_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     opcode_i,
  input  logic [PIDX_W-1:0]        point_index_i,
  input  logic signed [COORD_W-1:0] point_x_i,
  input  logic signed [COORD_W-1:0] point_z_i,
  input  logic [PARAM_T_W-1:0]     param_t_i,
  input  logic                     active_points_we_i,
  input  logic [AP_W-1:0]          active_points_i,
  output logic                     result_valid_o,
  output logic signed [POS_W-1:0]  pos_x_o,
  output logic signed [POS_W-1:0]  pos_z_o,
  output logic signed [GRAD_W-1:0] grad_x_o,
  output logic signed [GRAD_W-1:0] grad_z_o
);

  localparam int AW  = $clog2(MAX_POINTS);
  localparam int NW  = $clog2(MAX_POINTS + 1);
  localparam int CW  = (NW > AP_W) ? NW : AP_W;
  localparam int IXW = ((AW > PIDX_W) ? AW : PIDX_W) + 1;
  localparam int DW  = 2 * COORD_W;

  // Order in which the four polynomial chains run.
  typedef enum logic [1:0] {
    CH_POS_X,
    CH_GRAD_X,
    CH_POS_Z,
    CH_GRAD_Z
  } chain_e;

  state_e state_q, state_d;
  chain_e chain_q, chain_d;
  logic [2:0]      rd_cnt_q, rd_cnt_d;
  logic            result_valid_q, result_valid_d;
  logic [AP_W-1:0] active_points_q;

  logic [T_FRAC_BITS-1:0]   frac_q;
  logic [AW-1:0]            idx_q [4];
  logic signed [COORD_W-1:0] px_q [4];
  logic signed [COORD_W-1:0] pz_q [4];
  logic signed [POS_W-1:0]  pos_x_q, pos_z_q;
  logic signed [GRAD_W-1:0] grad_x_q, grad_z_q;

  // Sequencer outputs.
  logic accept, eval_accept, wr_accept;
  logic idx_start, mac_start, rd_capture, mac_capture;

  // Point count clamped to 1 .. MAX_POINTS.
  logic [CW-1:0] ap_ext;
  logic [NW-1:0] n_eff;

  logic          mem_we;
  logic [AW-1:0] mem_raddr;
  logic [DW-1:0] mem_rdata;
  logic [1:0]    rd_tag;

  logic          idx_done;
  logic [AW-1:0] i0, i1, i2, i3;

  mac_cfg_t         mac_cfg;
  logic             mac_done;
  logic [ACC_W-1:0] mac_acc;

  logic signed [COORD_W-1:0] pa [4];
  logic signed [COEF_W-1:0]  e0, e1, e2, e3;
  logic signed [COEF_W-1:0]  c0, c1, c2, c3;

  // ---------------------------------------------------------------------
  // Configuration register.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_points_q <= AP_RESET;
    end else if (active_points_we_i) begin
      active_points_q <= active_points_i;
    end
  end

  always_comb begin
    ap_ext = CW'(active_points_q);
    if (ap_ext == '0) begin
      n_eff = NW'(1);
    end else if (ap_ext > CW'(MAX_POINTS)) begin
      n_eff = NW'(MAX_POINTS);
    end else begin
      n_eff = NW'(ap_ext);
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer: next state.
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (eval_accept) begin
          state_d = ST_INDEX;
        end
      end
      ST_INDEX: begin
        if (idx_done) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (rd_cnt_q == 3'd4) begin
          state_d = ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (mac_done) begin
          state_d = (chain_q == CH_GRAD_Z) ? ST_IDLE : ST_LAUNCH;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer: outputs.
  // ---------------------------------------------------------------------
  always_comb begin
    busy        = (state_q != ST_IDLE);
    accept      = start && (state_q == ST_IDLE);
    eval_accept = accept && (opcode_i == OP_EVAL);
    wr_accept   = accept && (opcode_i == OP_WRITE);
    idx_start   = eval_accept;
    rd_capture  = (state_q == ST_READ) && (rd_cnt_q != 3'd0);
    mac_start   = (state_q == ST_LAUNCH);
    mac_capture = (state_q == ST_WAIT) && mac_done;

    rd_cnt_d       = (state_q == ST_READ) ? (rd_cnt_q + 3'd1) : 3'd0;
    result_valid_d = mac_capture && (chain_q == CH_GRAD_Z);
    chain_d        = chain_q;
    if (eval_accept) begin
      chain_d = CH_POS_X;
    end else if (mac_capture) begin
      chain_d = chain_e'(chain_q + 2'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      chain_q        <= CH_POS_X;
      rd_cnt_q       <= 3'd0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      chain_q        <= chain_d;
      rd_cnt_q       <= rd_cnt_d;
      result_valid_q <= result_valid_d;
    end
  end

  // ---------------------------------------------------------------------
  // Point memory. Writes happen only in idle and reads only while busy, so
  // a read never meets a write to the same slot.
  // ---------------------------------------------------------------------
  assign mem_we    = wr_accept && (IXW'(point_index_i) < IXW'(MAX_POINTS));
  assign mem_raddr = idx_q[rd_cnt_q[1:0]];
  assign rd_tag    = 2'(rd_cnt_q - 3'd1);

  ccr_point_mem #(
    .MAX_POINTS(MAX_POINTS)
  ) u_point_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(AW'(point_index_i)),
    .wdata_i({point_z_i, point_x_i}),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // ---------------------------------------------------------------------
  // Segment reduction and neighbor slots.
  // ---------------------------------------------------------------------
  ccr_seg_index #(
    .MAX_POINTS(MAX_POINTS)
  ) u_seg_index (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(idx_start),
    .seg_i  (param_t_i[PARAM_T_W-1:T_FRAC_BITS]),
    .n_i    (n_eff),
    .done_o (idx_done),
    .i0_o   (i0),
    .i1_o   (i1),
    .i2_o   (i2),
    .i3_o   (i3)
  );

  always_ff @(posedge clk_i) begin
    if (eval_accept) begin
      frac_q <= param_t_i[T_FRAC_BITS-1:0];
    end
    if ((state_q == ST_INDEX) && idx_done) begin
      idx_q[0] <= i0;
      idx_q[1] <= i1;
      idx_q[2] <= i2;
      idx_q[3] <= i3;
    end
    if (rd_capture) begin
      px_q[rd_tag] <= $signed(mem_rdata[COORD_W-1:0]);
      pz_q[rd_tag] <= $signed(mem_rdata[DW-1:COORD_W]);
    end
  end

  // ---------------------------------------------------------------------
  // Basis coefficients of the axis of the running chain.
  //   c0 = 2 P1, c1 = P2 - P0, c2 = 2 P0 - 5 P1 + 4 P2 - P3,
  //   c3 = -P0 + 3 P1 - 3 P2 + P3.
  // Position runs c3, c2, c1, c0; the slope runs 3 c3, 2 c2, c1.
  // ---------------------------------------------------------------------
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pa[k] = chain_q[1] ? pz_q[k] : px_q[k];
    end
    e0 = COEF_W'(pa[0]);
    e1 = COEF_W'(pa[1]);
    e2 = COEF_W'(pa[2]);
    e3 = COEF_W'(pa[3]);
    c0 = e1 <<< 1;
    c1 = e2 - e0;
    c2 = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
    c3 = e3 - e0 + ((e1 <<< 1) + e1) - ((e2 <<< 1) + e2);

    if (chain_q[0]) begin
      mac_cfg.lead      = (c3 <<< 1) + c3;
      mac_cfg.add0      = c2 <<< 1;
      mac_cfg.add1      = c1;
      mac_cfg.add2      = '0;
      mac_cfg.last_step = 2'd1;
    end else begin
      mac_cfg.lead      = c3;
      mac_cfg.add0      = c2;
      mac_cfg.add1      = c1;
      mac_cfg.add2      = c0;
      mac_cfg.last_step = 2'd2;
    end
  end

  ccr_horner_mac u_horner_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mac_start),
    .cfg_i  (mac_cfg),
    .frac_i (frac_q),
    .done_o (mac_done),
    .acc_o  (mac_acc)
  );

  // The final halving and fraction scaling is a plain bit pick, which is an
  // arithmetic right shift and so rounds toward minus infinity.
  always_ff @(posedge clk_i) begin
    if (mac_capture) begin
      case (chain_q)
        CH_POS_X:  pos_x_q  <= $signed(mac_acc[POS_LSB +: POS_W]);
        CH_GRAD_X: grad_x_q <= $signed(mac_acc[GRAD_LSB +: GRAD_W]);
        CH_POS_Z:  pos_z_q  <= $signed(mac_acc[POS_LSB +: POS_W]);
        CH_GRAD_Z: grad_z_q <= $signed(mac_acc[GRAD_LSB +: GRAD_W]);
        default:   pos_x_q  <= pos_x_q;
      endcase
    end
  end

  assign result_valid_o = result_valid_q;
  assign pos_x_o        = pos_x_q;
  assign pos_z_o        = pos_z_q;
  assign grad_x_o       = grad_x_q;
  assign grad_z_o       = grad_z_q;

endmodule

FILE: sv/ccr_point_mem.sv
// Control point store: one synchronous memory of {z, x} pairs.
// One write port and one read port with registered read data. Uses ccr_pkg.
module ccr_point_mem import ccr_pkg::*; #(
  parameter int MAX_POINTS = 64,
  localparam int AW = $clog2(MAX_POINTS),
  localparam int DW = 2 * COORD_W
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [MAX_POINTS];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/ccr_seg_index.sv
// Segment index unit: reduces the segment number modulo the point count
// one bit per cycle and derives the four neighbor slots. Uses ccr_pkg.
module ccr_seg_index import ccr_pkg::*; #(
  parameter int MAX_POINTS = 64,
  localparam int AW = $clog2(MAX_POINTS),
  localparam int NW = $clog2(MAX_POINTS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SEG_W-1:0] seg_i,
  input  logic [NW-1:0]    n_i,
  output logic             done_o,
  output logic [AW-1:0]    i0_o,
  output logic [AW-1:0]    i1_o,
  output logic [AW-1:0]    i2_o,
  output logic [AW-1:0]    i3_o
);

  localparam int CNT_W = $clog2(SEG_W + 1);

  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SEG_W-1:0] seg_q, seg_d;
  logic [NW-1:0]    rem_q, rem_d;

  logic [NW:0]   trial;
  logic [NW:0]   n_ext;
  logic [NW-1:0] nb1, nb2, i0n, i2n, i3n;

  // Restoring remainder step: shift in the next segment bit, subtract n if it fits.
  always_comb begin
    n_ext = {1'b0, n_i};
    trial = {rem_q, seg_q[SEG_W-1]};
    if (trial >= n_ext) begin
      rem_d = NW'(trial - n_ext);
    end else begin
      rem_d = NW'(trial);
    end
  end

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    seg_d  = seg_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = CNT_W'(SEG_W);
      seg_d = seg_i;
    end else if (run_q) begin
      cnt_d = cnt_q - CNT_W'(1);
      seg_d = seg_q << 1;
      if (cnt_q == CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seg_q <= seg_d;
    if (start_i) begin
      rem_q <= '0;
    end else if (run_q) begin
      rem_q <= rem_d;
    end
  end

  // Neighbors around the reduced segment, wrapping at the point count.
  always_comb begin
    nb1 = rem_q + NW'(1);
    i2n = (nb1 == n_i) ? '0 : nb1;
    nb2 = i2n + NW'(1);
    i3n = (nb2 == n_i) ? '0 : nb2;
    i0n = (rem_q == '0) ? (n_i - NW'(1)) : (rem_q - NW'(1));
  end

  assign done_o = done_q;
  assign i0_o   = AW'(i0n);
  assign i1_o   = AW'(rem_q);
  assign i2_o   = AW'(i2n);
  assign i3_o   = AW'(i3n);

endmodule

FILE: sv/ccr_horner_mac.sv
// Horner evaluator: runs one polynomial chain acc = acc * f + addend << k,
// multiplying by the fraction one 4-bit digit per cycle. Uses ccr_pkg.
module ccr_horner_mac import ccr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  mac_cfg_t               cfg_i,
  input  logic [T_FRAC_BITS-1:0] frac_i,
  output logic                   done_o,
  output logic [ACC_W-1:0]       acc_o
);

  localparam logic [DIG_CNT_W-1:0] LAST_DIG = DIG_CNT_W'(N_DIG - 1);

  logic                 run_q, done_q;
  logic [1:0]           step_q;
  logic [DIG_CNT_W-1:0] dig_q;
  logic [ACC_W-1:0]     acc_q, r_q;

  logic [DIG_CNT_W-1:0]     dig_sel;
  logic [DIG_W-1:0]         digit;
  logic [ACC_W+DIG_W-1:0]   prod;
  logic [ACC_W-1:0]         r_d;
  logic [1:0]               step_nx;
  logic signed [COEF_W-1:0] add_sel;
  logic [ACC_W-1:0]         preload;
  logic                     last_dig, last_step;

  // Digits of the fraction are taken most significant first.
  always_comb begin
    dig_sel = LAST_DIG - dig_q;
    digit   = frac_i[dig_sel * DIG_W +: DIG_W];
    prod    = acc_q * digit;
    r_d     = (r_q << DIG_W) + prod[ACC_W-1:0];
  end

  // The partial sum of a step starts at its addend, pre-scaled so that the
  // digit shifts bring it to its final weight.
  always_comb begin
    step_nx = start_i ? 2'd0 : (step_q + 2'd1);
    case (step_nx)
      2'd0:    add_sel = cfg_i.add0;
      2'd1:    add_sel = cfg_i.add1;
      default: add_sel = cfg_i.add2;
    endcase
    preload = ACC_W'(add_sel) << (T_FRAC_BITS * step_nx);
  end

  assign last_dig  = (dig_q == LAST_DIG);
  assign last_step = (step_q == cfg_i.last_step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      dig_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= '0;
        dig_q  <= '0;
      end else if (run_q) begin
        if (last_dig) begin
          dig_q <= '0;
          if (last_step) begin
            run_q  <= 1'b0;
            done_q <= 1'b1;
          end else begin
            step_q <= step_q + 2'd1;
          end
        end else begin
          dig_q <= dig_q + DIG_CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= ACC_W'(cfg_i.lead);
      r_q   <= preload;
    end else if (run_q) begin
      if (last_dig) begin
        acc_q <= r_d;
        r_q   <= preload;
      end else begin
        r_q <= r_d;
      end
    end
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule

FILE: sv/ccr_checker.sv
// Port-level checks for the spline evaluator, and the bind that attaches them.
// Depends on ccr_pkg and closed_catmull_rom_spline_eval_core.
module ccr_checker import ccr_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic opcode_i,
  input logic result_valid_o
);

  // Each evaluation runs through every sequencer state before its result, so result beats never touch.
  a_strobe_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  // A result beat is shown only once the block is free again.
  a_result_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result beat while busy");

  // An accepted evaluate beat makes the block busy.
  a_eval_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (opcode_i == OP_EVAL)) |=> busy)
    else $error("evaluate beat did not raise busy");

  // A write beat finishes in its own cycle and produces no result.
  a_write_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (opcode_i == OP_WRITE)) |=> (!busy && !result_valid_o))
    else $error("write beat raised busy or a result");

  // Busy only drops together with the result of the evaluation.
  a_busy_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o)
    else $error("busy dropped without a result beat");

endmodule

bind closed_catmull_rom_spline_eval_core ccr_checker u_ccr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .opcode_i      (opcode_i),
  .result_valid_o(result_valid_o)
);

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for closed_catmull_rom_spline_eval_core.
// Depends on ccr_pkg and the core; holds its own spline predictor and result queue.

module tb;
  import ccr_pkg::*;

  // The core is built with its default of 64 point slots.
  localparam int MAX_PTS = 64;
  // Once nothing is pending, the bench waits this long before a point-count write,
  // so a write beat still in the pipe is done.
  localparam int DRAIN_CYCLES = 80;
  // The longest quiet stretch in a correct run is a long gap, one evaluation and a
  // config pause. The watchdog limit is set above that stretch.
  localparam int QUIET_LIMIT = 2000;
  localparam int RAND_PER_PHASE = 90;
  localparam int N_PHASES = 11;

  // One command beat as the bench drives it.
  typedef struct {
    opcode_e                   op;
    logic [PIDX_W-1:0]         slot;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] z;
    logic [PARAM_T_W-1:0]      t;
  } spline_cmd_t;

  // One result beat: position and slope on both axes.
  typedef struct {
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_z;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_z;
  } curve_sample_t;

  // A row of the directed table. When typed is set, want holds a hand-written answer.
  typedef struct {
    spline_cmd_t   cmd;
    bit            typed;
    curve_sample_t want;
  } dir_row_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      start;
  logic                      busy;
  logic                      opcode_i;
  logic [PIDX_W-1:0]         point_index_i;
  logic signed [COORD_W-1:0] point_x_i;
  logic signed [COORD_W-1:0] point_z_i;
  logic [PARAM_T_W-1:0]      param_t_i;
  logic                      active_points_we_i;
  logic [AP_W-1:0]           active_points_i;
  logic                      result_valid_o;
  logic signed [POS_W-1:0]   pos_x_o;
  logic signed [POS_W-1:0]   pos_z_o;
  logic signed [GRAD_W-1:0]  grad_x_o;
  logic signed [GRAD_W-1:0]  grad_z_o;

  closed_catmull_rom_spline_eval_core #(.MAX_POINTS(MAX_PTS)) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .opcode_i           (opcode_i),
    .point_index_i      (point_index_i),
    .point_x_i          (point_x_i),
    .point_z_i          (point_z_i),
    .param_t_i          (param_t_i),
    .active_points_we_i (active_points_we_i),
    .active_points_i    (active_points_i),
    .result_valid_o     (result_valid_o),
    .pos_x_o            (pos_x_o),
    .pos_z_o            (pos_z_o),
    .grad_x_o           (grad_x_o),
    .grad_z_o           (grad_z_o)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: a shadow of the point store, which slots have been written,
  // and the point count register.
  logic signed [COORD_W-1:0] knot_x [MAX_PTS];
  logic signed [COORD_W-1:0] knot_z [MAX_PTS];
  bit                        knot_set [MAX_PTS];
  logic [AP_W-1:0]           loop_count;

  curve_sample_t pending_samples [$];
  int            mismatch_count;
  dir_row_t      dir_table [$];

  // The register value 0 acts as a one-point loop, values above the slot count
  // act as the full store.
  function automatic int loop_len();
    int n;
    n = int'(loop_count);
    if (n < 1) n = 1;
    if (n > MAX_PTS) n = MAX_PTS;
    return n;
  endfunction

  // The segment index wraps modulo the loop length; the previous point wraps
  // back to the end of the loop, the next two wrap forward to its start.
  function automatic void loop_neighbors(input logic [PARAM_T_W-1:0] t,
                                         output int i0, output int i1,
                                         output int i2, output int i3);
    int n;
    int seg;
    n = loop_len();
    seg = int'(t >> T_FRAC_BITS);
    i1 = seg % n;
    i2 = (i1 + 1) % n;
    i3 = (i1 + 2) % n;
    i0 = (i1 >= 1) ? i1 - 1 : n - 1;
  endfunction

  // One axis of the uniform Catmull-Rom basis, exact in 128 bits. The halving
  // and the fraction scaling fold into one arithmetic shift, so results round
  // toward minus infinity.
  function automatic void axis_eval(input logic signed [COORD_W-1:0] p0,
                                    input logic signed [COORD_W-1:0] p1,
                                    input logic signed [COORD_W-1:0] p2,
                                    input logic signed [COORD_W-1:0] p3,
                                    input logic [T_FRAC_BITS-1:0] frac,
                                    output logic signed [POS_W-1:0] pos,
                                    output logic signed [GRAD_W-1:0] grad);
    logic signed [127:0] a0, a1, a2, a3, f;
    logic signed [127:0] c0, c1, c2, c3, acc;
    a0 = 128'(p0);
    a1 = 128'(p1);
    a2 = 128'(p2);
    a3 = 128'(p3);
    f = {{(128 - T_FRAC_BITS){1'b0}}, frac};
    c0 = 2 * a1;
    c1 = a2 - a0;
    c2 = 2 * a0 - 5 * a1 + 4 * a2 - a3;
    c3 = -a0 + 3 * a1 - 3 * a2 + a3;
    acc = ((c3 * f + (c2 <<< T_FRAC_BITS)) * f + (c1 <<< (2 * T_FRAC_BITS))) * f
          + (c0 <<< (3 * T_FRAC_BITS));
    pos = acc[POS_LSB +: POS_W];
    acc = (3 * c3 * f + ((2 * c2) <<< T_FRAC_BITS)) * f + (c1 <<< (2 * T_FRAC_BITS));
    grad = acc[GRAD_LSB +: GRAD_W];
  endfunction

  function automatic curve_sample_t predict_curve(input logic [PARAM_T_W-1:0] t);
    curve_sample_t s;
    int i0, i1, i2, i3;
    logic [T_FRAC_BITS-1:0] frac;
    loop_neighbors(t, i0, i1, i2, i3);
    frac = t[T_FRAC_BITS-1:0];
    axis_eval(knot_x[i0], knot_x[i1], knot_x[i2], knot_x[i3], frac, s.pos_x, s.grad_x);
    axis_eval(knot_z[i0], knot_z[i1], knot_z[i2], knot_z[i3], frac, s.pos_z, s.grad_z);
    return s;
  endfunction

  function automatic dir_row_t dir_row(input opcode_e op, input int slot, input int x,
                                       input int z, input int t, input bit typed,
                                       input int px, input int pz,
                                       input int gx, input int gz);
    dir_row_t r;
    r.cmd.op = op;
    r.cmd.slot = PIDX_W'(slot);
    r.cmd.x = COORD_W'(x);
    r.cmd.z = COORD_W'(z);
    r.cmd.t = PARAM_T_W'(t);
    r.typed = typed;
    r.want.pos_x = POS_W'(px);
    r.want.pos_z = POS_W'(pz);
    r.want.grad_x = GRAD_W'(gx);
    r.want.grad_z = GRAD_W'(gz);
    return r;
  endfunction

  // Appends one row at the end of the directed table.
  function automatic void append_row(input dir_row_t r);
    dir_table = {dir_table, r};
  endfunction

  // Coordinates lean on the corners of the Q8.8 range now and then.
  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return COORD_W'(-32768);
      1: return COORD_W'(32767);
      2: return COORD_W'(0);
      3: return COORD_W'(-1);
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // Mostly back to back or short gaps, now and then a long one, so that the next
  // beat lands at varied points of an evaluation in flight.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 90);
  endfunction

  // Random beat. An evaluation that would read a slot never written becomes a
  // write to that slot, so the store fills as the loop grows.
  task automatic random_cmd(output spline_cmd_t c);
    int i0, i1, i2, i3;
    int r;
    c.slot = PIDX_W'($urandom_range(0, MAX_PTS - 1));
    c.x = rand_coord();
    c.z = rand_coord();
    r = $urandom_range(0, 19);
    if (r < 14) c.t = PARAM_T_W'($urandom);
    else if (r < 17) c.t = {PARAM_T_W'($urandom)} & ~PARAM_T_W'((1 << T_FRAC_BITS) - 1);
    else c.t = {PARAM_T_W'($urandom)} | PARAM_T_W'((1 << T_FRAC_BITS) - 1);
    c.op = ($urandom_range(0, 99) < 55) ? OP_EVAL : OP_WRITE;
    if (c.op == OP_EVAL) begin
      loop_neighbors(c.t, i0, i1, i2, i3);
      if (!knot_set[i0]) begin
        c.op = OP_WRITE;
        c.slot = PIDX_W'(i0);
      end else if (!knot_set[i1]) begin
        c.op = OP_WRITE;
        c.slot = PIDX_W'(i1);
      end else if (!knot_set[i2]) begin
        c.op = OP_WRITE;
        c.slot = PIDX_W'(i2);
      end else if (!knot_set[i3]) begin
        c.op = OP_WRITE;
        c.slot = PIDX_W'(i3);
      end
    end
  endtask

  // Drives one command beat and holds it until the core takes it. Called at a
  // rising edge; returns at a rising edge with start already set for what follows.
  // The slot field is six bits wide, so a write past the store cannot be issued.
  task automatic issue_beat(input spline_cmd_t c, input bit typed,
                            input curve_sample_t want, input bit no_idle,
                            input bit last);
    int gap;
    curve_sample_t exp_s;
    start <= 1'b1;
    opcode_i <= c.op;
    point_index_i <= c.slot;
    point_x_i <= c.x;
    point_z_i <= c.z;
    param_t_i <= c.t;
    do @(posedge clk_i); while (busy !== 1'b0);
    if (c.op == OP_WRITE) begin
      knot_x[c.slot] = c.x;
      knot_z[c.slot] = c.z;
      knot_set[c.slot] = 1'b1;
    end else begin
      exp_s = typed ? want : predict_curve(c.t);
      pending_samples = {pending_samples, exp_s};
    end
    gap = no_idle ? 0 : pick_gap();
    if (last && gap == 0) gap = 1;
    // start is touched once per edge: either the next beat keeps it high or it drops here.
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // The point count is written only with the core idle: nothing pending, and
  // enough cycles after that for any write beat to have finished.
  task automatic set_loop_count(input logic [AP_W-1:0] v);
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    active_points_we_i <= 1'b1;
    active_points_i <= v;
    @(posedge clk_i);
    active_points_we_i <= 1'b0;
    loop_count = v;
  endtask

  task automatic note_mismatch(input string what, input logic signed [31:0] got,
                               input logic signed [31:0] want);
    if (mismatch_count < 100)
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // Result checker. A result beat is valid for exactly one cycle and is taken at
  // the edge that ends it; values are sampled before that edge updates them.
  always @(posedge clk_i) begin
    curve_sample_t want;
    if (rst_ni === 1'b1 && result_valid_o === 1'b1) begin
      if (pending_samples.size() == 0) begin
        note_mismatch("result beat with nothing pending, pos_x", 32'(pos_x_o), 0);
      end else begin
        want = pending_samples.pop_front();
        if (pos_x_o !== want.pos_x)
          note_mismatch("pos_x", 32'(pos_x_o), 32'(want.pos_x));
        if (pos_z_o !== want.pos_z)
          note_mismatch("pos_z", 32'(pos_z_o), 32'(want.pos_z));
        if (grad_x_o !== want.grad_x)
          note_mismatch("grad_x", 32'(grad_x_o), 32'(want.grad_x));
        if (grad_z_o !== want.grad_z)
          note_mismatch("grad_z", 32'(grad_z_o), 32'(want.grad_z));
      end
    end
  end

  // Watchdog: counts edges at which neither a command beat nor a result beat
  // moves. A hung core ends the run here.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((start === 1'b1 && busy === 1'b0) || result_valid_o === 1'b1) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [AP_W-1:0] phase_counts [8];
    logic [AP_W-1:0] count;
    spline_cmd_t     c;
    curve_sample_t   blank;
    bit              no_idle;

    clk_i = 1'b0;
    rst_ni = 1'b0;
    start = 1'b0;
    opcode_i = OP_WRITE;
    point_index_i = '0;
    point_x_i = '0;
    point_z_i = '0;
    param_t_i = '0;
    active_points_we_i = 1'b0;
    active_points_i = '0;
    mismatch_count = 0;
    loop_count = AP_RESET;
    blank = '{default: '0};
    foreach (knot_set[i]) knot_set[i] = 1'b0;

    // The count settings visited after the directed part: the one-point loop,
    // zero (treated as one), the largest code (clamped to the store), the full
    // store, small loops, and one just past the store.
    phase_counts = '{1, 0, 127, 64, 4, 2, 3, 65};

    // Directed part, run with the point count left at its reset value of ten.
    // First the ten loop points, all at the positive x corner and negative z corner.
    for (int k = 0; k < 10; k++)
      append_row(dir_row(OP_WRITE, k, 32767, -32768, 0, 0, 0, 0, 0, 0));
    // With every neighbor equal the curve sits on the point and has no slope.
    append_row(dir_row(OP_EVAL, 0, 0, 0, 0, 1, 32767, -32768, 0, 0));
    // Largest parameter: segment 63 wraps into the loop, the fraction is all ones.
    append_row(dir_row(OP_EVAL, 0, 0, 0, 'h3FFFFF, 1, 32767, -32768, 0, 0));
    append_row(dir_row(OP_WRITE, 5, 'h0100, -256, 0, 0, 0, 0, 0, 0));
    // At a zero fraction the curve is on its start point, and the slope is half
    // the difference of the outer neighbors, which are equal here.
    append_row(dir_row(OP_EVAL, 0, 0, 0, 5 << 16, 1, 256, -256, 0, 0));
    append_row(dir_row(OP_EVAL, 0, 0, 0, (4 << 16) | 'h8000, 0, 0, 0, 0, 0));
    append_row(dir_row(OP_EVAL, 0, 0, 0, (5 << 16) | 'hFFFF, 0, 0, 0, 0, 0));
    append_row(dir_row(OP_WRITE, 9, -32768, 32767, 0, 0, 0, 0, 0, 0));
    // Last segment: the two points ahead wrap to the start of the loop.
    append_row(dir_row(OP_EVAL, 0, 0, 0, (9 << 16) | 'h4000, 0, 0, 0, 0, 0));
    // First segment: the point behind wraps to the end of the loop.
    append_row(dir_row(OP_EVAL, 0, 0, 0, 'hC000, 0, 0, 0, 0, 0));
    // Top slot, outside the loop of ten, must not disturb it.
    append_row(dir_row(OP_WRITE, 63, 'h5A5A, 'hA5A5, 0, 0, 0, 0, 0, 0));
    append_row(dir_row(OP_WRITE, 0, -1, 1, 0, 0, 0, 0, 0, 0));
    append_row(dir_row(OP_EVAL, 0, 0, 0, 1, 0, 0, 0, 0, 0));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_table[i])
      issue_beat(dir_table[i].cmd, dir_table[i].typed, dir_table[i].want, 1'b0,
                 i == dir_table.size() - 1);

    // Random part: one point count per phase, the last few chosen at random.
    // Some phases run without any gaps at all.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      count = (ph < 8) ? phase_counts[ph] : AP_W'($urandom_range(0, 127));
      set_loop_count(count);
      no_idle = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        random_cmd(c);
        issue_beat(c, 1'b0, blank, no_idle, k == RAND_PER_PHASE - 1);
      end
    end

    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
